// ----- rtl/psf_pkg.sv -----
// package for the predicate select filter: types, codes and constants
package psf_pkg;

   localparam int unsigned ROW_INDEX_W = 16;
   localparam int unsigned COUNT_W     = 17;
   localparam longint unsigned MAX_ROWS_DEFAULT = 64'd65536;

   typedef enum logic [1:0] {
      CSR_COMPARE_OP = 2'd0,
      CSR_THRESHOLD  = 2'd1,
      CSR_SINGLE     = 2'd2,
      CSR_LIMIT      = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_EQ = 3'd0,
      OP_NE = 3'd1,
      OP_LT = 3'd2,
      OP_LE = 3'd3,
      OP_GT = 3'd4,
      OP_GE = 3'd5
   } compare_op_type;

   typedef struct packed {
      logic [63:0] value_bits;
      logic        is_null;
      logic        last_row;
   } req_type;

   typedef struct packed {
      logic [ROW_INDEX_W-1:0] row_index;
      logic                   selected;
      logic [COUNT_W-1:0]     selected_total;
      logic                   scan_done;
   } rsp_type;

endpackage

// ----- rtl/predicate_select_filter_top.sv -----
// predicate select filter: ieee compare of each row against a threshold, with counters
//
// Each row item yields one result item. The block takes one row in every cycle while the
// output is not held by rsp_ready: the input register feeds an ieee compare and the
// counter update, which land in the result register, so a row's result passes the
// input register and then the result register before it appears. The result stage is a
// single register that refills in the same cycle it is taken.
// Configuration writes are taken at any time but must only be made while idle.
module predicate_select_filter_top
   import psf_pkg::*;
#(
   parameter longint unsigned MAX_ROWS = MAX_ROWS_DEFAULT,
   localparam int unsigned ROW_W = (MAX_ROWS <= 64'd2) ? 1 : $clog2(MAX_ROWS)
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam logic [ROW_W-1:0]   ROW_LAST  = ROW_W'(MAX_ROWS - 64'd1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   logic [2:0]  op_ff;
   logic [63:0] thr_ff;
   logic        single_ff;
   logic [COUNT_W-1:0] limit_ff;

   logic        in_valid_ff;
   req_type     in_ff;
   logic        out_valid_ff;
   rsp_type     out_ff;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;

   logic advance;
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff     <= OP_EQ;
         thr_ff    <= '0;
         single_ff <= 1'b0;
         limit_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_COMPARE_OP: op_ff     <= csr_data[2:0];
            CSR_THRESHOLD:  thr_ff    <= csr_data;
            CSR_SINGLE:     single_ff <= csr_data[0];
            CSR_LIMIT:      limit_ff  <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // ieee compare: map to sign-magnitude order, handle nan and signed zero
   logic a_nan, b_nan, both_zero, a_neg, b_neg, mag_lt, mag_eq;
   logic eq, lt, gt, match;
   logic [62:0] a_mag, b_mag;
   always_comb begin
      if (single_ff) begin
         a_neg = in_ff.value_bits[31];
         b_neg = thr_ff[31];
         a_mag = {32'd0, in_ff.value_bits[30:0]};
         b_mag = {32'd0, thr_ff[30:0]};
         a_nan = (in_ff.value_bits[30:23] == 8'hff) && (in_ff.value_bits[22:0] != '0);
         b_nan = (thr_ff[30:23] == 8'hff) && (thr_ff[22:0] != '0);
      end else begin
         a_neg = in_ff.value_bits[63];
         b_neg = thr_ff[63];
         a_mag = in_ff.value_bits[62:0];
         b_mag = thr_ff[62:0];
         a_nan = (in_ff.value_bits[62:52] == 11'h7ff) && (in_ff.value_bits[51:0] != '0);
         b_nan = (thr_ff[62:52] == 11'h7ff) && (thr_ff[51:0] != '0);
      end
      mag_lt    = a_mag < b_mag;
      mag_eq    = a_mag == b_mag;
      both_zero = (a_mag == '0) && (b_mag == '0);
      eq = !a_nan && !b_nan && (both_zero || (mag_eq && a_neg == b_neg));
      if (a_nan || b_nan || eq)  lt = 1'b0;
      else if (a_neg != b_neg)   lt = a_neg;
      else                       lt = a_neg ? (!mag_lt && !mag_eq) : mag_lt;
      gt = !a_nan && !b_nan && !eq && !lt;
      case (op_ff)
         OP_EQ:   match = eq;
         OP_NE:   match = !eq;
         OP_LT:   match = lt;
         OP_LE:   match = lt || eq;
         OP_GT:   match = gt;
         OP_GE:   match = gt || eq;
         default: match = 1'b0;
      endcase
   end

   logic room, sel;
   logic [COUNT_W-1:0] cnt_next;
   always_comb begin
      room     = (limit_ff == '0) || (cnt_ff < limit_ff);
      sel      = match && !in_ff.is_null && room;
      cnt_next = (sel && cnt_ff != COUNT_MAX) ? cnt_ff + 1'b1 : cnt_ff;
      if (in_ff.last_row) begin
         row_in = '0;
         cnt_in = '0;
      end else begin
         row_in = (row_ff == ROW_LAST) ? '0 : row_ff + 1'b1;
         cnt_in = cnt_next;
      end
   end

   logic fire;
   assign fire = in_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         row_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (advance)   out_valid_ff <= in_valid_ff;
         if (fire) begin
            row_ff <= row_in;
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) in_ff <= req_data;
      if (fire) begin
         out_ff.row_index      <= ROW_INDEX_W'({{(64 - ROW_W){1'b0}}, row_ff});
         out_ff.selected       <= sel;
         out_ff.selected_total <= cnt_next;
         out_ff.scan_done      <= in_ff.last_row;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      fire && in_ff.last_row |=> row_ff == '0 && cnt_ff == '0)
      else $error("counters not cleared after last row");
   a_limit: assert property (@(posedge clock) disable iff (reset)
      fire && limit_ff != '0 && cnt_ff >= limit_ff |-> !sel)
      else $error("row selected past limit");
   a_null: assert property (@(posedge clock) disable iff (reset)
      fire && in_ff.is_null |-> !sel)
      else $error("null row selected");

endmodule
